// ----- rtl/egd_pkg.sv -----
// Shared types, constants and table lookups for the Exp-Golomb code decoder.
package egd_pkg;

    localparam int WINDOW_BITS_DEF = 32;
    localparam int MAX_PREFIX_DEF  = 15;

    localparam int VALUE_W     = 20;
    localparam int LEN_W       = 5;
    localparam int REQ_W       = 3;
    localparam int RANGE_W     = 8;
    localparam int RICE_K_W    = 4;
    localparam int RICE_MAX_K  = 15;
    localparam int MAP_ENTRIES = 48;
    localparam int MAP_IDX_W   = 6;

    localparam int IN_USER_W   = REQ_W + 1;
    localparam int OUT_DATA_W  = ((VALUE_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 1;

    localparam logic [REQ_W-1:0] REQ_UNSIGNED  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SIGNED    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MAPPED    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TRUNCATED = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RICE      = 3'd4;

    typedef logic [MAP_IDX_W-1:0] map_val_t;

    localparam map_val_t CBP_INTRA [MAP_ENTRIES] = '{
        6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
        6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
        6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
        6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
    };

    localparam map_val_t CBP_INTER [MAP_ENTRIES] = '{
        6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
        6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
        6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
        6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
        6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
    };

    function automatic map_val_t cbp_lookup(input logic sel, input logic [MAP_IDX_W-1:0] idx);
        map_val_t r;
        r = '0;
        if (idx < MAP_IDX_W'(MAP_ENTRIES))
        begin
            r = sel ? CBP_INTER[idx] : CBP_INTRA[idx];
        end
        return r;
    endfunction

endpackage

// ----- rtl/exp_golomb_code_decoder.sv -----
// Exp-Golomb / Golomb-Rice code decoder top level.
//
// Input stream (s_axis): one request word per code. tdata carries the bit
// window (first stream bit in the MSB of that field), the truncated-mode range
// and the Rice parameter; tuser carries the request type and the table select.
// Output stream (m_axis): decoded value and code length in tdata, error in tuser.
//
// Every word passes an input register, the decode logic (leading-zero count,
// suffix shift, table lookup) and a result register that drives the output;
// throughput is one word per cycle while the receiver does not stall.
// s_axis_tready stays high while either register is free or the result is
// being taken, so a new word is accepted while a finished one waits; with the
// receiver stalled, the block holds two words and then drops tready.
// Reset (rst_n low, asynchronous) empties both registers; there is no
// configuration and no state kept between words.
module exp_golomb_code_decoder #(
    parameter int WINDOW_BITS = egd_pkg::WINDOW_BITS_DEF,
    parameter int MAX_PREFIX  = egd_pkg::MAX_PREFIX_DEF,
    parameter int IN_DATA_W   = ((WINDOW_BITS + egd_pkg::RANGE_W + egd_pkg::RICE_K_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bit_window, trunc_range, rice_k, zero pad
    input  logic [IN_DATA_W-1:0]            s_axis_tdata,
    // req_type, map_select
    input  logic [egd_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // value, code_length, zero pad
    output logic [egd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // error
    output logic [egd_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import egd_pkg::*;

    localparam int PAD_W  = 2 * MAX_PREFIX + RICE_MAX_K + 2;
    localparam int EXT_W  = WINDOW_BITS + PAD_W;
    localparam int SH_W   = $clog2(EXT_W);
    localparam int ZW     = $clog2(MAX_PREFIX + 2);
    localparam int CODE_W = MAX_PREFIX + 1;
    localparam int RK_W   = RICE_MAX_K + 1;
    localparam int RV_W   = ZW + RICE_MAX_K;
    localparam int LW     = ZW + LEN_W + 1;
    localparam int WIDE_A = (CODE_W > RV_W) ? CODE_W : RV_W;
    localparam int WIDE_W = (WIDE_A > VALUE_W) ? WIDE_A : VALUE_W;
    localparam int RANGE_LO = WINDOW_BITS;
    localparam int RICE_LO  = WINDOW_BITS + RANGE_W;

    logic                   in_valid_reg, in_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [REQ_W-1:0]       req_reg;
    logic [WINDOW_BITS-1:0] win_reg;
    logic                   sel_reg;
    logic [RANGE_W-1:0]     range_reg;
    logic [RICE_K_W-1:0]    k_reg;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   err_reg, err_next;

    logic in_load, in_move;

    logic [EXT_W-1:0]  ext;
    logic [ZW-1:0]     zcnt;
    logic              too_long;
    logic [SH_W-1:0]   eg_sh, rc_sh;
    logic [EXT_W-1:0]  eg_bits, rc_bits;
    logic [CODE_W-1:0] eg_mask, code;
    logic [RK_W-1:0]   rc_mask, rc_suffix;
    logic [RV_W-1:0]   rc_val;
    logic [WIDE_W-1:0] code_w, mag_w, sgn_w, rc_w;
    logic [LW-1:0]     eg_len_w, rc_len_w;
    logic [LEN_W-1:0]  eg_len, rc_len;
    map_val_t          map_val;

    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign in_load = s_axis_tvalid && s_axis_tready;
    assign in_move = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_valid_next  = in_load || (in_valid_reg && !in_move);
    assign out_valid_next = in_move || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            req_reg   <= s_axis_tuser[REQ_W-1:0];
            sel_reg   <= s_axis_tuser[REQ_W];
            win_reg   <= s_axis_tdata[WINDOW_BITS-1:0];
            range_reg <= s_axis_tdata[RANGE_LO +: RANGE_W];
            k_reg     <= s_axis_tdata[RICE_LO +: RICE_K_W];
        end
        if (in_move)
        begin
            value_reg <= value_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
        end
    end

    // window with zero fill past its end; stream bit p sits at ext[EXT_W-1-p]
    assign ext = {win_reg, {PAD_W{1'b0}}};

    always_comb
    begin
        zcnt = ZW'(MAX_PREFIX + 1);
        for (int i = MAX_PREFIX; i >= 0; i--)
        begin
            if (ext[EXT_W-1-i])
            begin
                zcnt = ZW'(i);
            end
        end
    end

    assign too_long = (zcnt == ZW'(MAX_PREFIX + 1));

    // Exp-Golomb suffix: bits z+1 .. 2z
    assign eg_sh   = SH_W'(EXT_W - 1) - SH_W'({zcnt, 1'b0});
    assign eg_bits = ext >> eg_sh;
    assign eg_mask = (CODE_W'(1) << zcnt) - CODE_W'(1);
    assign code    = eg_mask + (eg_bits[CODE_W-1:0] & eg_mask);

    // Golomb-Rice suffix: bits z+1 .. z+k
    assign rc_sh     = SH_W'(EXT_W - 1) - SH_W'(zcnt) - SH_W'(k_reg);
    assign rc_bits   = ext >> rc_sh;
    assign rc_mask   = (RK_W'(1) << k_reg) - RK_W'(1);
    assign rc_suffix = rc_bits[RK_W-1:0] & rc_mask;
    assign rc_val    = (RV_W'(zcnt) << k_reg) | RV_W'(rc_suffix);

    assign code_w = WIDE_W'(code);
    assign mag_w  = (code_w + WIDE_W'(1)) >> 1;
    assign sgn_w  = code[0] ? mag_w : (WIDE_W'(0) - mag_w);
    assign rc_w   = WIDE_W'(rc_val);

    assign eg_len_w = LW'({zcnt, 1'b0}) + LW'(1);
    assign rc_len_w = LW'(zcnt) + LW'(k_reg) + LW'(1);
    assign eg_len   = eg_len_w[LEN_W-1:0];
    assign rc_len   = rc_len_w[LEN_W-1:0];

    assign map_val = cbp_lookup(sel_reg, code[MAP_IDX_W-1:0]);

    always_comb
    begin
        value_next = '0;
        len_next   = '0;
        err_next   = 1'b0;
        case (req_reg)
            REQ_UNSIGNED, REQ_SIGNED, REQ_MAPPED, REQ_TRUNCATED:
            begin
                if ((req_reg == REQ_TRUNCATED) && (range_reg <= RANGE_W'(1)))
                begin
                    value_next = VALUE_W'(!ext[EXT_W-1]);
                    len_next   = LEN_W'(1);
                end
                else if (too_long)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    len_next = eg_len;
                    if (req_reg == REQ_SIGNED)
                    begin
                        value_next = sgn_w[VALUE_W-1:0];
                    end
                    else if (req_reg == REQ_MAPPED)
                    begin
                        if (code >= CODE_W'(MAP_ENTRIES))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            value_next = VALUE_W'(map_val);
                        end
                    end
                    else
                    begin
                        value_next = code_w[VALUE_W-1:0];
                    end
                end
            end
            REQ_RICE:
            begin
                if (too_long)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    value_next = rc_w[VALUE_W-1:0];
                    len_next   = rc_len;
                end
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({len_reg, value_reg});
    assign m_axis_tuser  = OUT_USER_W'(err_reg);

endmodule

// ----- rtl/egd_checker.sv -----
// Port-level checks for the Exp-Golomb code decoder, bound to the top level.
module egd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [egd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [egd_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import egd_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // error words carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[VALUE_W-1:0] == '0))
        else $error("error word with nonzero value");

    // input backpressure only when both stages hold words and the sink stalls
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a result appearing on an empty output was accepted and passed the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching input word");

endmodule

bind exp_golomb_code_decoder egd_checker u_egd_checker (.*);
